>>> design/spjq_pkg.sv
`default_nettype none

package spjq_pkg;

    // default sizes of the queue
    localparam int DEPTH_DEF   = 16;
    localparam int PRIO_W_DEF  = 8;

    // fixed field widths on the channels
    localparam int REQ_TYPE_W  = 2;
    localparam int IN_PRIO_W   = 8;
    localparam int PAYLOAD_W   = 32;
    localparam int COUNT_OUT_W = 5;

    // request codes; the fourth code is unused and ignored
    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_ENQ  = 2'd0,
        REQ_DEQ  = 2'd1,
        REQ_PEEK = 2'd2
    } t_req_code;

    // request beat
    typedef struct packed {
        logic [REQ_TYPE_W-1:0] req_type;
        logic [IN_PRIO_W-1:0]  job_priority;
        logic [PAYLOAD_W-1:0]  job_payload;
    } t_req;

    // result beat
    typedef struct packed {
        logic                   job_valid;
        logic [IN_PRIO_W-1:0]   out_priority;
        logic [PAYLOAD_W-1:0]   out_payload;
        logic                   accepted;
        logic [COUNT_OUT_W-1:0] job_count;
        logic                   is_empty;
        logic                   is_full;
    } t_rsp;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic enq;
        logic deq;
    } t_cell_ctrl;

endpackage

`default_nettype wire

>>> design/spjq_if.sv
`default_nettype none

// request channel
interface spjq_req_if import spjq_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// result channel
interface spjq_rsp_if import spjq_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> design/stable_priority_job_queue_core.sv
// Stable priority job queue, held in a chain of slot cells sorted by
// ascending priority value; jobs of equal priority leave in arrival order.
// Request channel i_req: enqueue, dequeue or peek. Each request beat gives
// exactly one result beat on o_rsp with the returned job (dequeue, peek),
// the accept flag of an enqueue, the job count and the empty and full flags.
// Every cell compares its own priority with the incoming one, so an insert
// or a removal moves the whole chain at once.
// The result beat appears in the cycle after the request beat is accepted.
// Throughput: one request per cycle, limited by the single result register;
// a new request is taken while the result register is empty or being read.
// When the receiver stalls, the result holds and i_req.ready drops until the
// result is taken.
// Reset (synchronous, active low) empties the queue and drops any pending
// result; no clearing pass is needed.
// Enqueues of priority zero or into a full queue are dropped with accepted 0;
// dequeue or peek of an empty queue returns a zero job with job_valid 0.
`default_nettype none

module stable_priority_job_queue_core import spjq_pkg::*; #(
    parameter int DEPTH  = DEPTH_DEF,
    parameter int PRIO_W = PRIO_W_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    spjq_req_if.sink    i_req,
    spjq_rsp_if.source  o_rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                 cell_valid   [DEPTH];
    logic                 cell_gt      [DEPTH];
    logic [PRIO_W-1:0]    cell_prio    [DEPTH];
    logic [PAYLOAD_W-1:0] cell_payload [DEPTH];

    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic                 r_out_valid;
    logic                 n_out_valid;
    t_rsp                 r_rsp;
    t_rsp                 n_rsp;

    logic                 accept;
    logic                 is_enq;
    logic                 is_deq;
    logic                 is_peek;
    logic                 q_empty;
    logic                 q_full;
    logic                 enq_ok;
    logic                 deq_ok;
    t_cell_ctrl           ctrl;
    logic [PRIO_W-1:0]    new_prio;
    logic [PRIO_W+IN_PRIO_W-1:0]   prio_in_ext;
    logic [PRIO_W+IN_PRIO_W-1:0]   prio_out_ext;
    logic [CNT_W+COUNT_OUT_W-1:0]  count_ext;

    // handshake on the request side
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;

    // decode
    assign is_enq  = i_req.data.req_type == REQ_ENQ;
    assign is_deq  = i_req.data.req_type == REQ_DEQ;
    assign is_peek = i_req.data.req_type == REQ_PEEK;
    assign q_empty = r_count == '0;
    assign q_full  = r_count == CNT_W'(DEPTH);

    // incoming priority fitted to the stored width
    assign prio_in_ext = {{PRIO_W{1'b0}}, i_req.data.job_priority};
    assign new_prio    = prio_in_ext[PRIO_W-1:0];

    assign enq_ok   = accept && is_enq && !q_full && (new_prio != '0);
    assign deq_ok   = accept && is_deq && !q_empty;
    assign ctrl.enq = enq_ok;
    assign ctrl.deq = deq_ok;

    // chain of slot cells, head at index zero
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic                 left_valid;
        logic                 left_gt;
        logic [PRIO_W-1:0]    left_prio;
        logic [PAYLOAD_W-1:0] left_payload;
        logic                 right_valid;
        logic [PRIO_W-1:0]    right_prio;
        logic [PAYLOAD_W-1:0] right_payload;

        if (i == 0) begin : g_head
            assign left_valid   = 1'b1;
            assign left_gt      = 1'b0;
            assign left_prio    = '0;
            assign left_payload = '0;
        end else begin : g_mid
            assign left_valid   = cell_valid[i-1];
            assign left_gt      = cell_gt[i-1];
            assign left_prio    = cell_prio[i-1];
            assign left_payload = cell_payload[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign right_valid   = 1'b0;
            assign right_prio    = '0;
            assign right_payload = '0;
        end else begin : g_body
            assign right_valid   = cell_valid[i+1];
            assign right_prio    = cell_prio[i+1];
            assign right_payload = cell_payload[i+1];
        end

        spjq_cell #(
            .PRIO_W (PRIO_W)
        ) u_cell (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_ctrl          (ctrl),
            .i_new_prio      (new_prio),
            .i_new_payload   (i_req.data.job_payload),
            .i_left_valid    (left_valid),
            .i_left_gt       (left_gt),
            .i_left_prio     (left_prio),
            .i_left_payload  (left_payload),
            .i_right_valid   (right_valid),
            .i_right_prio    (right_prio),
            .i_right_payload (right_payload),
            .o_valid         (cell_valid[i]),
            .o_gt            (cell_gt[i]),
            .o_prio          (cell_prio[i]),
            .o_payload       (cell_payload[i])
        );
    end

    // job count after the request
    always_comb begin
        n_count = r_count;
        if (enq_ok) begin
            n_count = r_count + CNT_W'(1);
        end else if (deq_ok) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    assign count_ext    = {{COUNT_OUT_W{1'b0}}, n_count};
    assign prio_out_ext = {{IN_PRIO_W{1'b0}}, cell_prio[0]};

    // result beat built from the head slot
    always_comb begin
        n_rsp              = '0;
        n_rsp.accepted     = enq_ok;
        n_rsp.job_count    = count_ext[COUNT_OUT_W-1:0];
        n_rsp.is_empty     = n_count == '0;
        n_rsp.is_full      = n_count == CNT_W'(DEPTH);
        if ((is_deq || is_peek) && !q_empty) begin
            n_rsp.job_valid    = 1'b1;
            n_rsp.out_priority = prio_out_ext[IN_PRIO_W-1:0];
            n_rsp.out_payload  = cell_payload[0];
        end
    end

    // result register valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (accept) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_rsp;

endmodule

`default_nettype wire

>>> design/spjq_cell.sv
`default_nettype none

module spjq_cell import spjq_pkg::*; #(
    parameter int PRIO_W = PRIO_W_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cell_ctrl           i_ctrl,
    input  wire logic [PRIO_W-1:0]    i_new_prio,
    input  wire logic [PAYLOAD_W-1:0] i_new_payload,
    input  wire logic                 i_left_valid,
    input  wire logic                 i_left_gt,
    input  wire logic [PRIO_W-1:0]    i_left_prio,
    input  wire logic [PAYLOAD_W-1:0] i_left_payload,
    input  wire logic                 i_right_valid,
    input  wire logic [PRIO_W-1:0]    i_right_prio,
    input  wire logic [PAYLOAD_W-1:0] i_right_payload,
    output logic                      o_valid,
    output logic                      o_gt,
    output logic [PRIO_W-1:0]         o_prio,
    output logic [PAYLOAD_W-1:0]      o_payload
);

    logic                 r_valid;
    logic [PRIO_W-1:0]    r_prio;
    logic [PAYLOAD_W-1:0] r_payload;
    logic                 n_valid;
    logic [PRIO_W-1:0]    n_prio;
    logic [PAYLOAD_W-1:0] n_payload;

    // held job leaves after the new one
    assign o_gt = r_valid && (r_prio > i_new_prio);

    // deq shifts left; enq shifts right or takes the new job at the boundary
    always_comb begin
        n_valid   = r_valid;
        n_prio    = r_prio;
        n_payload = r_payload;
        if (i_ctrl.deq) begin
            n_valid   = i_right_valid;
            n_prio    = i_right_prio;
            n_payload = i_right_payload;
        end else if (i_ctrl.enq) begin
            if (i_left_gt) begin
                n_valid   = i_left_valid;
                n_prio    = i_left_prio;
                n_payload = i_left_payload;
            end else if (o_gt || (!r_valid && i_left_valid)) begin
                n_valid   = 1'b1;
                n_prio    = i_new_prio;
                n_payload = i_new_payload;
            end
        end
    end

    // slot valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // slot contents
    always_ff @(posedge i_clk) begin
        r_prio    <= n_prio;
        r_payload <= n_payload;
    end

    assign o_valid   = r_valid;
    assign o_prio    = r_prio;
    assign o_payload = r_payload;

endmodule

`default_nettype wire

>>> design/spjq_checker.sv
`default_nettype none

module spjq_checker import spjq_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_req_valid,
    input wire logic i_req_ready,
    input wire logic i_rsp_valid,
    input wire logic i_rsp_ready,
    input wire t_rsp i_rsp_data
);

    // an empty queue reports a zero count
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_data.is_empty |-> i_rsp_data.job_count == '0)
        else $error("empty flag with nonzero count");

    // a stored job and a returned job never come from the same beat
    a_acc_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> !(i_rsp_data.accepted && i_rsp_data.job_valid))
        else $error("accept and job return in one beat");

    // a returned job never carries priority zero, an absent job is all zero
    a_job_prio: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_data.job_valid ? (i_rsp_data.out_priority != '0)
                         : (i_rsp_data.out_priority == '0
                            && i_rsp_data.out_payload == '0)))
        else $error("returned job priority mismatch");

    // a stalled result beat holds its value
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_data))
        else $error("result beat changed while stalled");

    // every accepted request beat shows a result beat in the next cycle
    a_req_to_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> i_rsp_valid)
        else $error("accepted request without result beat");

endmodule

bind stable_priority_job_queue_core spjq_checker u_spjq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);

`default_nettype wire

>>> sim/tb.sv
`default_nettype none

module tb;
    import spjq_pkg::*;

    localparam int QDEPTH = DEPTH_DEF;
    localparam int QPRIO_W = PRIO_W_DEF;
    localparam logic [IN_PRIO_W-1:0] PRIO_MASK = IN_PRIO_W'((64'd1 << QPRIO_W) - 1);
    // the fourth request code has no name in the package
    localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;
    localparam int MAX_PRINTED = 60;

    logic i_clk;
    logic i_rst_n;

    spjq_req_if req_if ();
    spjq_rsp_if rsp_if ();

    stable_priority_job_queue_core #(
        .DEPTH  (QDEPTH),
        .PRIO_W (QPRIO_W)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // shadow copy of the sorted job slots
    logic [IN_PRIO_W-1:0] slot_prio [QDEPTH];
    logic [PAYLOAD_W-1:0] slot_pay  [QDEPTH];
    int                   held;

    t_rsp rsp_due [$];
    int   mismatch_count;
    int   src_idle_pct;
    int   snk_idle_pct;
    int   stall_left;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #(8 * 400000);
        $display("end of test: mismatches");
        $finish;
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (mismatch_count < MAX_PRINTED)
            $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // expected result of one request; updates the shadow slots
    function automatic t_rsp predict_result(t_req r);
        t_rsp                 res;
        int                   pos;
        logic [IN_PRIO_W-1:0] p;
        res = '0;
        p = r.job_priority & PRIO_MASK;
        case (r.req_type)
            REQ_ENQ: begin
                if (held < QDEPTH && p != '0) begin
                    // stable insert behind every job of equal or lower value
                    pos = held;
                    while (pos > 0 && slot_prio[pos-1] > p) begin
                        slot_prio[pos] = slot_prio[pos-1];
                        slot_pay[pos]  = slot_pay[pos-1];
                        pos--;
                    end
                    slot_prio[pos] = p;
                    slot_pay[pos]  = r.job_payload;
                    held++;
                    res.accepted = 1'b1;
                end
            end
            REQ_DEQ, REQ_PEEK: begin
                if (held > 0) begin
                    res.job_valid    = 1'b1;
                    res.out_priority = slot_prio[0];
                    res.out_payload  = slot_pay[0];
                    if (r.req_type == REQ_DEQ) begin
                        for (int i = 0; i + 1 < held; i++) begin
                            slot_prio[i] = slot_prio[i+1];
                            slot_pay[i]  = slot_pay[i+1];
                        end
                        held--;
                        slot_prio[held] = '0;
                        slot_pay[held]  = '0;
                    end
                end
            end
            default: ;
        endcase
        res.job_count = COUNT_OUT_W'(held);
        res.is_empty  = (held == 0);
        res.is_full   = (held == QDEPTH);
        return res;
    endfunction

    // prediction on accepted requests, checking of accepted results
    always @(posedge i_clk) begin : scoreboard
        t_rsp want;
        t_rsp got;
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready)
                rsp_due.push_back(predict_result(req_if.data));
            if (rsp_if.valid && rsp_if.ready) begin
                got = rsp_if.data;
                if (rsp_due.size() == 0) begin
                    report_mismatch("result with nothing pending", got[31:0], '0);
                end else begin
                    want = rsp_due.pop_front();
                    if (got.job_valid !== want.job_valid)
                        report_mismatch("job_valid", 32'(got.job_valid),
                                        32'(want.job_valid));
                    if (got.out_priority !== want.out_priority)
                        report_mismatch("out_priority", 32'(got.out_priority),
                                        32'(want.out_priority));
                    if (got.out_payload !== want.out_payload)
                        report_mismatch("out_payload", got.out_payload, want.out_payload);
                    if (got.accepted !== want.accepted)
                        report_mismatch("accepted", 32'(got.accepted),
                                        32'(want.accepted));
                    if (got.job_count !== want.job_count)
                        report_mismatch("job_count", 32'(got.job_count),
                                        32'(want.job_count));
                    if (got.is_empty !== want.is_empty)
                        report_mismatch("is_empty", 32'(got.is_empty),
                                        32'(want.is_empty));
                    if (got.is_full !== want.is_full)
                        report_mismatch("is_full", 32'(got.is_full),
                                        32'(want.is_full));
                end
            end
        end
    end

    // result receiver with random stalls and long hold-offs
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0)
                rsp_if.ready <= 1'b0;
            else
                rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // hold-off counter
    always @(posedge i_clk) begin
        if (stall_left > 0)
            stall_left <= stall_left - 1;
    end

    function automatic t_req make_req(logic [REQ_TYPE_W-1:0] kind,
                                      logic [IN_PRIO_W-1:0] prio,
                                      logic [PAYLOAD_W-1:0] payload);
        t_req r;
        r.req_type     = kind;
        r.job_priority = prio;
        r.job_payload  = payload;
        return r;
    endfunction

    // send one request beat, with a random gap in front
    task automatic send_req(t_req r);
        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    // random request: enq_pct sets the fill trend, span narrows priorities for ties
    function automatic t_req random_req(int enq_pct, int span);
        int                   roll;
        logic [IN_PRIO_W-1:0] prio;
        roll = $urandom_range(99);
        if ($urandom_range(99) < 4)
            prio = '0;
        else if ($urandom_range(1))
            prio = IN_PRIO_W'($urandom_range(span, 1));
        else
            prio = IN_PRIO_W'($urandom_range(255, 1));
        if (roll < 3)
            return make_req(REQ_UNUSED, IN_PRIO_W'($urandom), $urandom);
        if (roll < 3 + enq_pct)
            return make_req(REQ_ENQ, prio, $urandom);
        if ($urandom_range(3) == 0)
            return make_req(REQ_PEEK, IN_PRIO_W'($urandom), $urandom);
        return make_req(REQ_DEQ, IN_PRIO_W'($urandom), $urandom);
    endfunction

    // dequeue, peek and ignored code on an empty queue, zero priority rejected
    task automatic test_empty_queue();
        send_req(make_req(REQ_DEQ, 8'hFF, 32'hFFFF_FFFF));
        send_req(make_req(REQ_PEEK, 8'h00, 32'h0000_0000));
        send_req(make_req(REQ_UNUSED, 8'hFF, 32'hFFFF_FFFF));
        send_req(make_req(REQ_ENQ, 8'h00, 32'hFFFF_FFFF));
    endtask

    // fill to the top with extremes and equal priorities
    task automatic test_fill_order();
        logic [IN_PRIO_W-1:0] prios [16] = '{8'hFF, 8'h01, 8'h05, 8'h05, 8'h80, 8'h05,
                                              8'h55, 8'hAA, 8'hFF, 8'h01, 8'hC8, 8'h02,
                                              8'h80, 8'h7F, 8'h05, 8'h03};
        logic [PAYLOAD_W-1:0] pay;
        for (int i = 0; i < 16; i++) begin
            pay = (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : 32'hA5A5_0000 + i;
            send_req(make_req(REQ_ENQ, prios[i], pay));
        end
    endtask

    // enqueue into a full queue, ignored code, then peek and dequeue
    task automatic test_full_queue();
        send_req(make_req(REQ_ENQ, 8'h01, 32'h1234_5678));
        send_req(make_req(REQ_UNUSED, 8'h00, 32'h0));
        send_req(make_req(REQ_PEEK, 8'h00, 32'h0));
        send_req(make_req(REQ_DEQ, 8'h00, 32'h0));
        send_req(make_req(REQ_DEQ, 8'h00, 32'h0));
    endtask

    // bursts with a fill trend each, so the queue swings between empty and full
    task automatic test_random_traffic(int n_items);
        int sent;
        int burst;
        int enq_pct;
        int span;
        sent = 0;
        while (sent < n_items) begin
            burst = $urandom_range(60, 20);
            case ($urandom_range(2))
                0: enq_pct = 25;
                1: enq_pct = 50;
                default: enq_pct = 75;
            endcase
            case ($urandom_range(2))
                0: span = 2;
                1: span = 8;
                default: span = 255;
            endcase
            for (int i = 0; i < burst && sent < n_items; i++) begin
                send_req(random_req(enq_pct, span));
                sent++;
            end
        end
    endtask

    // receiver holds off while requests keep coming, so the input stalls
    task automatic test_backpressure();
        int saved_idle;
        saved_idle = src_idle_pct;
        src_idle_pct = 0;
        stall_left = 64;
        for (int i = 0; i < 40; i++)
            send_req(random_req(60, 8));
        src_idle_pct = saved_idle;
    endtask

    initial begin
        i_rst_n        = 1'b0;
        req_if.valid   = 1'b0;
        req_if.data    = '0;
        held           = 0;
        mismatch_count = 0;
        stall_left     = 0;
        src_idle_pct   = 28;
        snk_idle_pct   = 70;
        for (int i = 0; i < QDEPTH; i++) begin
            slot_prio[i] = '0;
            slot_pay[i]  = '0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_queue();
        test_fill_order();
        test_full_queue();
        test_random_traffic(420);

        src_idle_pct = 70;
        snk_idle_pct = 28;
        test_backpressure();
        test_random_traffic(420);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random_traffic(410);

        // drain and settle
        req_if.valid <= 1'b0;
        while (rsp_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatch_count == 0 && rsp_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
